### design/aht_pkg.sv
// aht_pkg: shared types and constants of the age histogram block
// used by age_histogram_tenure_threshold and its port checker
package aht_pkg;

  // histogram shape
  localparam int MAX_AGE   = 15;
  localparam int DEPTH     = MAX_AGE + 1;
  localparam int AGE_W     = $clog2(DEPTH);
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 36;

  // configuration widths
  localparam int CAP_W     = 32;
  localparam int OCC_W     = 17;
  localparam int SIZE_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // compute datapath widths
  localparam int TGT_W     = CAP_W + OCC_W - 16;
  localparam int RUN_W     = CNT_W + SIZE_W + AGE_W;

  // input fields
  localparam int OP_W      = 3;
  localparam int AGEIN_W   = 8;
  localparam int NTH_W     = 8;
  localparam int IN_W      = 24;

  // output fields
  localparam int THR_W     = 4;
  localparam int OUT_W     = 112;
  localparam int OUT_CNT_LO = THR_W + 1;
  localparam int OUT_TOT_LO = OUT_CNT_LO + CNT_W;
  localparam int OUT_PRM_LO = OUT_TOT_LO + SUM_W;

  // reset values
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(6);
  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1048576);
  localparam logic [OCC_W-1:0]  OCC_RESET  = OCC_W'(32768);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_RECORD  = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_COMPUTE = 3'd2,
    OP_SET     = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCCUPANCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBJ_SIZE  = 2'd2;

endpackage

### design/age_histogram_tenure_threshold.sv
// age_histogram_tenure_threshold: survival age histogram with tenuring threshold
// histogram held in a 16-entry synchronous RAM, swept once per transaction (twice for compute)
// depends on aht_pkg
//
//  channel  | direction | contents (lowest bits first)
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | operation[2:0] age[10:3] new_threshold[18:11]
//  m_axis   | out       | threshold promote count_at_age total promoted_count
//  cfg      | in        | write enable, register index, write data
//
// one transaction at a time; a record reads and then writes its age entry
// (no write for an age past the histogram), clear/set/query and other codes
// go straight to the report; each report is a 16-entry sweep over the RAM read
// port plus pipeline drain (compute adds one more sweep through a multiply stage).
// reset (rst, synchronous) clears all histogram valid bits at once, threshold 6.
// a result waits in the output register; the next transaction is taken meanwhile
// and only its final load waits for m_axis_tready.
module age_histogram_tenure_threshold import aht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // operation, age, new_threshold
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // threshold, promote, count_at_age, total_survivors, promoted_count, zero pad
  output logic [OUT_W-1:0]     m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_REC_RD  = 7'b0000010,
    ST_REC_WR  = 7'b0000100,
    ST_CMP     = 7'b0001000,
    ST_CMP_END = 7'b0010000,
    ST_RPT     = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [CAP_W-1:0]  capacity;
  logic [OCC_W-1:0]  occupancy;
  logic [SIZE_W-1:0] obj_size;

  // latched transaction
  logic [AGEIN_W-1:0] age_q;

  logic [THR_W-1:0]  thr;

  // histogram RAM and valid bits
  logic [CNT_W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [AGE_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  rd_data;
  logic              rd_valid;
  logic              wr_en;
  logic [CNT_W-1:0]  cur_cnt;

  // sweep pipeline
  logic [AGE_W:0]    issue_cnt;
  logic              issue;
  logic              p1_vld, p2_vld;
  logic [AGE_W-1:0]  p1_idx, p2_idx;
  logic [RUN_W-1:0]  p2_prod;
  logic              sweep_done;

  // compute and report accumulators
  logic [TGT_W-1:0]  target;
  logic [RUN_W-1:0]  running, running_sum;
  logic              found;
  logic [THR_W-1:0]  found_thr;
  logic [SUM_W-1:0]  total, promoted;
  logic [CNT_W-1:0]  cnt_at;

  logic              in_fire;
  logic              age_in_range;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign age_in_range  = (age_q <= AGEIN_W'(MAX_AGE));
  assign issue         = (state == ST_CMP || state == ST_RPT) && !issue_cnt[AGE_W];
  assign sweep_done    = issue_cnt[AGE_W] && !p1_vld && !p2_vld;
  assign cur_cnt       = rd_valid ? rd_data : '0;
  assign wr_en         = (state == ST_REC_WR) && (cur_cnt != '1);
  assign running_sum   = running + p2_prod;

  // read address: the recorded age, else the sweep position
  always_comb begin
    rd_addr = issue_cnt[AGE_W-1:0];
    if (state == ST_REC_RD) begin
      rd_addr = age_q[AGE_W-1:0];
    end
  end

  // histogram RAM, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[age_q[AGE_W-1:0]] <= cur_cnt + CNT_W'(1);
    end
    rd_data  <= mem[rd_addr];
  end

  // valid bits: an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (state == ST_IDLE && in_fire && op_t'(s_axis_tdata[OP_W-1:0]) == OP_CLEAR) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[age_q[AGE_W-1:0]] <= 1'b1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      occupancy <= OCC_RESET;
      obj_size  <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CAPACITY:  capacity  <= cfg_data[CAP_W-1:0];
        REG_OCCUPANCY: occupancy <= cfg_data[OCC_W-1:0];
        REG_OBJ_SIZE:  obj_size  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_t'(s_axis_tdata[OP_W-1:0]))
            OP_RECORD:  state_next = ST_REC_RD;
            OP_COMPUTE: state_next = ST_CMP;
            default:    state_next = ST_RPT;
          endcase
        end
      end
      ST_REC_RD:  state_next = age_in_range ? ST_REC_WR : ST_RPT;
      ST_REC_WR:  state_next = ST_RPT;
      ST_CMP:     state_next = sweep_done ? ST_CMP_END : ST_CMP;
      ST_CMP_END: state_next = ST_RPT;
      ST_RPT:     state_next = sweep_done ? ST_FINISH : ST_RPT;
      ST_FINISH:  state_next = (!m_axis_tvalid || m_axis_tready) ? ST_IDLE : ST_FINISH;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // transaction latch and threshold updates
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else begin
      if (state == ST_IDLE && in_fire) begin
        age_q <= s_axis_tdata[OP_W +: AGEIN_W];
        target <= TGT_W'((CAP_W+OCC_W)'(capacity) * (CAP_W+OCC_W)'(occupancy) >> 16);
        if (op_t'(s_axis_tdata[OP_W-1:0]) == OP_SET) begin
          if (s_axis_tdata[OP_W+AGEIN_W +: NTH_W] > NTH_W'(MAX_AGE)) begin
            thr <= THR_W'(MAX_AGE);
          end else begin
            thr <= s_axis_tdata[OP_W+AGEIN_W +: THR_W];
          end
        end
      end
      if (state == ST_CMP_END) begin
        thr <= found ? found_thr : THR_W'(MAX_AGE);
      end
    end
  end

  // sweep issue and pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
    end else begin
      p1_vld <= issue;
      p2_vld <= p1_vld && (state == ST_CMP);
      if (state == ST_IDLE || state == ST_CMP_END) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + (AGE_W+1)'(1);
      end
    end
  end

  // sweep datapath: multiply stage for compute, sums for the report
  always_ff @(posedge clk) begin
    p1_idx  <= issue_cnt[AGE_W-1:0];
    p2_idx  <= p1_idx;
    p2_prod <= RUN_W'(cur_cnt) * RUN_W'(obj_size);
    if (state == ST_IDLE) begin
      running <= '0;
      found   <= 1'b0;
      total   <= '0;
      promoted <= '0;
      cnt_at  <= '0;
    end else begin
      // running occupancy, first age past target sets the threshold (at least 1)
      if (p2_vld) begin
        running <= running_sum;
        if (!found && running_sum > RUN_W'(target)) begin
          found     <= 1'b1;
          found_thr <= (p2_idx == '0) ? THR_W'(1) : p2_idx;
        end
      end
      // report sums
      if (p1_vld && state == ST_RPT) begin
        total <= total + SUM_W'(cur_cnt);
        if (p1_idx >= thr) begin
          promoted <= promoted + SUM_W'(cur_cnt);
        end
        if (age_in_range && p1_idx == age_q[AGE_W-1:0]) begin
          cnt_at <= cur_cnt;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {(OUT_W-OUT_PRM_LO-SUM_W)'(0), promoted, total, cnt_at,
                       (age_q >= AGEIN_W'(thr)), thr};
    end
  end

endmodule

### design/aht_port_check.sv
// aht_port_check: port-level checks on the age histogram block
// depends on aht_pkg, bound to age_histogram_tenure_threshold
module aht_port_check import aht_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic [IN_W-1:0]      s_axis_tdata,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [OUT_W-1:0]     m_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready
);

  // one transaction in flight: ready drops after each accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  // promoted ages are a subset of all ages
  a_promoted_le_total: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_PRM_LO +: SUM_W] <= m_axis_tdata[OUT_TOT_LO +: SUM_W])
    else $error("promoted count exceeds total");

  // a single age count never exceeds the total
  a_count_le_total: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> SUM_W'(m_axis_tdata[OUT_CNT_LO +: CNT_W])
                      <= m_axis_tdata[OUT_TOT_LO +: SUM_W])
    else $error("age count exceeds total");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind age_histogram_tenure_threshold aht_port_check u_aht_port_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
